### rtl/assert_macros.svh
// Assertion macros used by the RTL of the voxel ray walker.
// Needs nothing but a SystemVerilog compiler with concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vrt_pkg.sv
// Types and constants of the voxel ray walker.
// Used by vrt_div and voxel_ray_traversal; no dependencies.
package vrt_pkg;
  localparam int TW = 40;
  localparam logic [TW-1:0] TInf = {TW{1'b1}};
  localparam int MaxRes = 14;
  localparam int DivBits = 31;

  localparam logic [0:0] RegRadius = 1'b0;
  localparam logic [0:0] RegEye = 1'b1;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } axis_e;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StDiv   = 5'b00010,
    StStep  = 5'b00100,
    StOut   = 5'b01000,
    StSetup = 5'b10000
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

### rtl/vrt_div.sv
// Restoring divider, one quotient bit per cycle, shared by all setup divisions.
// Depends on vrt_pkg.
module vrt_div import vrt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DivBits-1:0]   num_i,
  input  logic [15:0]          den_i,
  output div_ctl_t             ctl_o,
  output logic [DivBits-1:0]   quo_o
);
  logic [DivBits-1:0] num_q, num_d;
  logic [16:0]        rem_q, rem_d;
  logic [15:0]        den_q;
  logic [4:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [16:0]        trial;

  always_comb begin
    trial  = {rem_q[15:0], num_q[DivBits-1]};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = 5'(DivBits - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[DivBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};
  assign quo_o = num_q;
endmodule

### rtl/voxel_ray_traversal.sv
// Voxel ray walker top level: setup sequencer, DDA stepping and stream ports.
// Depends on vrt_pkg, vrt_div and assert_macros.svh.
//
// Usage: one ray enters on the s_axis channel as origin and direction. The
// block walks the voxel grid by 3D DDA and sends one transfer on m_axis for
// each cell entered, with tlast set on the final cell of the ray.
// Setup runs two divisions (tDelta and first-boundary distance) per moving
// axis, six at most, on one shared bit-serial divider; axes with a zero
// direction skip theirs. Each cell then passes through StStep, which picks
// the axis and advances, and StOut, which presents the result. A new ray is
// taken only once the last cell has been transferred.
// When the receiver holds m_axis_tready low, the walk waits with the cell
// held stable in the output register.
// The config channel writes the reach radius (index 0) and eye_height
// (index 1) and is always ready; it is to be used only between rays.
// Reset returns to idle with a reach radius of 4 and eye_height 384 (1.5).
// A radius of zero gives no cells; the ray then completes silently.
`include "assert_macros.svh"
module voxel_ray_traversal import vrt_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // origin_x[23:0], origin_y[47:24], origin_z[71:48], dir_x[87:72],
  // dir_y[103:88], dir_z[119:104]
  input  logic [119:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cell_x[15:0], cell_y[31:16], cell_z[47:32], face_axis[49:48],
  // face_positive[50], step_index[54:51], zero fill [55]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [9:0]  cfg_data_i
);
  localparam int PosW = 26 + FRAC_BITS;
  localparam logic [FRAC_BITS:0] One = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [3:0]  radius_q;
  logic [9:0]  eye_q;
  state_e      state_q;
  logic [15:0] cell_q [3];
  logic [TW-1:0] tmax_q [3];
  logic [TW-1:0] tdel_q [3];
  logic [15:0] mag_q [3];
  logic [2:0]  neg_q, zero_q;
  logic [FRAC_BITS:0] bnd_q [3];
  logic [3:0]  cnt_q [3];
  logic [1:0]  dax_q;
  logic        dsel_q;
  logic [3:0]  n_q;
  logic [6:0]  lim_q;
  logic [15:0] out_cell_q [3];
  logic [1:0]  out_ax_q;
  logic        out_pos_q, out_last_q;
  logic [3:0]  out_idx_q;

  div_ctl_t div_ctl;
  logic [DivBits-1:0] quo;
  logic        div_start;
  logic [DivBits-1:0] div_num;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 4'd4;
      eye_q    <= 10'd384;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRadius: radius_q <= cfg_data_i[3:0];
        RegEye:    eye_q    <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Axis choice and the sum of squared step counts after the step.
  logic [1:0] ax;
  logic [3:0] ncnt [3];
  logic [7:0] sq;
  logic [TW:0] tsum;
  always_comb begin
    if (tmax_q[0] < tmax_q[1] && tmax_q[0] < tmax_q[2]) ax = AxisX;
    else if (tmax_q[1] < tmax_q[2]) ax = AxisY;
    else ax = AxisZ;
    for (int a = 0; a < 3; a++) ncnt[a] = cnt_q[a] + 4'(ax == 2'(a));
    sq = 8'(ncnt[0]) * 8'(ncnt[0]) + 8'(ncnt[1]) * 8'(ncnt[1]) +
         8'(ncnt[2]) * 8'(ncnt[2]);
    tsum = {1'b0, tmax_q[ax]} + {1'b0, tdel_q[ax]};
  end

  assign div_num = dsel_q ? DivBits'(bnd_q[dax_q]) << (30 - FRAC_BITS)
                          : DivBits'(1) << 30;
  assign div_start = (state_q == StSetup);

  vrt_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(mag_q[dax_q]),
    .ctl_o(div_ctl), .quo_o(quo)
  );

  // Next axis with a division to run, starting at axis a.
  function automatic logic [2:0] next_ax(input logic [1:0] a, input logic [2:0] z);
    logic [2:0] r;
    r = 3'd3;
    for (int k = 2; k >= 0; k--) if (k >= int'(a) && !z[k]) r = 3'(k);
    return r;
  endfunction

  logic [PosW-1:0] p [3];
  logic signed [15:0] d [3];
  logic [2:0] nx0;
  always_comb begin
    p[0] = PosW'(signed'(s_axis_tdata[23:0]));
    p[1] = PosW'(signed'(s_axis_tdata[47:24])) + PosW'(eye_q);
    p[2] = PosW'(signed'(s_axis_tdata[71:48]));
    d[0] = s_axis_tdata[87:72];
    d[1] = s_axis_tdata[103:88];
    d[2] = s_axis_tdata[119:104];
    nx0 = next_ax(2'd0, {d[2] == 0, d[1] == 0, d[0] == 0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state_q)
        StIdle: if (s_axis_tvalid) begin
          state_q <= (nx0 == 3'd3) ? StStep : StSetup;
        end
        StSetup: state_q <= StDiv;
        StDiv: if (div_ctl.done) begin
          if (!dsel_q) state_q <= StSetup;
          else if (next_ax(dax_q + 2'd1, zero_q) == 3'd3 || dax_q == 2'd2) state_q <= StStep;
          else state_q <= StSetup;
        end
        StStep: begin
          if (lim_q == '0) state_q <= StIdle;
          else begin
            state_q <= StOut;
            m_axis_tvalid <= 1'b1;
          end
        end
        StOut: if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
          state_q <= out_last_q ? StIdle : StStep;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        for (int a = 0; a < 3; a++) begin
          cell_q[a] <= 16'(p[a] >> FRAC_BITS);
          neg_q[a]  <= d[a][15];
          zero_q[a] <= (d[a] == 0);
          mag_q[a]  <= d[a][15] ? 16'(-d[a]) : d[a];
          bnd_q[a]  <= !d[a][15] ? One - (FRAC_BITS+1)'(p[a][FRAC_BITS-1:0]) :
                       (p[a][FRAC_BITS-1:0] == 0 ? One : (FRAC_BITS+1)'(p[a][FRAC_BITS-1:0]));
          tmax_q[a] <= TInf;
          tdel_q[a] <= TInf;
          cnt_q[a]  <= '0;
        end
        dax_q  <= nx0[1:0];
        dsel_q <= 1'b0;
        n_q    <= '0;
        lim_q  <= (radius_q > 4'd8) ? 7'd64 : 7'(radius_q) * 7'(radius_q);
      end
      StDiv: if (div_ctl.done) begin
        if (!dsel_q) begin
          tdel_q[dax_q] <= TW'(quo);
          dsel_q <= 1'b1;
        end else begin
          tmax_q[dax_q] <= TW'(quo);
          dsel_q <= 1'b0;
          if (dax_q != 2'd2) begin
            logic [2:0] nx;
            nx = next_ax(dax_q + 2'd1, zero_q);
            if (nx != 3'd3) dax_q <= nx[1:0];
          end
        end
      end
      StStep: if (!(lim_q == 0)) begin
        tmax_q[ax] <= (tsum >= {1'b0, TInf}) ? TInf : tsum[TW-1:0];
        cell_q[ax] <= zero_q[ax] ? cell_q[ax] : (neg_q[ax] ? cell_q[ax] - 16'd1
                                                            : cell_q[ax] + 16'd1);
        for (int a = 0; a < 3; a++) begin
          cnt_q[a] <= ncnt[a];
          out_cell_q[a] <= (a == int'(ax)) ?
            (zero_q[ax] ? cell_q[ax] : (neg_q[ax] ? cell_q[ax] - 16'd1 : cell_q[ax] + 16'd1))
            : cell_q[a];
        end
        out_ax_q   <= ax;
        out_pos_q  <= neg_q[ax] && !zero_q[ax];
        out_idx_q  <= n_q;
        out_last_q <= ({1'b0, sq} >= {2'b0, lim_q}) || (n_q == 4'(MaxRes - 1));
        n_q <= n_q + 4'd1;
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {1'b0, out_idx_q, out_pos_q, out_ax_q,
                         out_cell_q[2], out_cell_q[1], out_cell_q[0]};
  assign m_axis_tlast = out_last_q;

  `ASSERT_IMPL(a_busy_not_ready, clk_i, rst_ni, state_q != StIdle, !s_axis_tready,
               "input ready while a ray is being walked")
  `ASSERT_IMPL(a_valid_in_out, clk_i, rst_ni, m_axis_tvalid, state_q == StOut,
               "output valid outside the output state")
  `ASSERT_NEXT(a_div_done, clk_i, rst_ni, div_ctl.done, !div_ctl.busy,
               "divider busy after completion")
  `ASSERT_IMPL(a_idx_range, clk_i, rst_ni, m_axis_tvalid, out_idx_q < 4'(MaxRes),
               "step index beyond the result limit")
endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for voxel_ray_traversal: rays go in on s_axis, and visited
// cells come out on m_axis. They are checked against an in-bench DDA walk predictor.
// Depends on vrt_pkg and the voxel_ray_traversal RTL.
`timescale 1ns / 100ps

module tb_top import vrt_pkg::*; ();

  typedef struct {
    logic signed [23:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
  } ray_t;

  typedef struct {
    logic [15:0] cx, cy, cz;
    axis_e       axis;
    logic        neg;
    logic [3:0]  idx;
    logic        last;
  } cell_t;

  // One directed row: a ray, plus the first visited cell where it is obvious by hand.
  typedef struct {
    ray_t  ray;
    bit    has_first;
    cell_t first;
  } row_t;

  localparam longint unsigned TMaxSat = 64'hFF_FFFF_FFFF;
  localparam int WatchLimit = 6000;
  localparam int SettleCycles = 400;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_index_i = RegRadius;
  logic [9:0]   cfg_data_i = '0;

  voxel_ray_traversal DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the block's register file, updated when a write is accepted.
  logic [3:0] radius_q = 4'd4;
  logic [9:0] eye_q = 10'd384;

  cell_t cells_due[$];
  int    mismatches = 0;
  bit    quiet = 1'b0;
  bit    first_due = 1'b0;
  cell_t first_cell;

  // Sets up one axis of the walk: the start cell, the step and the ray distances.
  function automatic void axis_init(input longint p, input longint d,
                                    output longint vox, output int stp,
                                    output longint unsigned tmax,
                                    output longint unsigned tdel);
    longint unsigned pb, frac, mag, b;
    pb = longint'(p) + (64'd1 << 40);
    frac = pb & 64'hFF;
    vox = longint'(pb >> 8) - (64'sd1 << 32);
    if (d == 0) begin
      stp = 0;
      tmax = TMaxSat;
      tdel = TMaxSat;
    end else begin
      mag = (d < 0) ? -d : d;
      if (d > 0) begin
        stp = 1;
        b = 256 - frac;
      end else begin
        stp = -1;
        b = (frac != 0) ? frac : 256;
      end
      tdel = (64'd1 << 30) / mag;
      tmax = (b << 22) / mag;
    end
  endfunction

  // Walks the ray as the block should and queues each cell it must send.
  task automatic walk_ray(input ray_t r);
    longint pos[3], dir[3], vox[3];
    longint unsigned tmax[3], tdel[3], cnt[3], lim, s;
    int stp[3];
    int n, ax;
    cell_t c;
    pos[0] = r.ox;
    pos[1] = longint'(r.oy) + longint'(eye_q);
    pos[2] = r.oz;
    dir[0] = r.dx;
    dir[1] = r.dy;
    dir[2] = r.dz;
    for (int a = 0; a < 3; a++) begin
      axis_init(pos[a], dir[a], vox[a], stp[a], tmax[a], tdel[a]);
      cnt[a] = 0;
    end
    lim = (radius_q > 8) ? 64 : radius_q * radius_q;
    n = 0;
    while (n < MaxRes && cnt[0] * cnt[0] + cnt[1] * cnt[1] + cnt[2] * cnt[2] < lim) begin
      if (tmax[0] < tmax[1] && tmax[0] < tmax[2]) ax = AxisX;
      else if (tmax[1] < tmax[2]) ax = AxisY;
      else ax = AxisZ;
      s = tmax[ax] + tdel[ax];
      tmax[ax] = (tmax[ax] >= TMaxSat || tdel[ax] >= TMaxSat || s >= TMaxSat) ?
                 TMaxSat : s;
      vox[ax] += stp[ax];
      cnt[ax]++;
      c.cx = vox[0][15:0];
      c.cy = vox[1][15:0];
      c.cz = vox[2][15:0];
      c.axis = axis_e'(ax);
      c.neg = (stp[ax] < 0);
      c.idx = n[3:0];
      c.last = (cnt[0] * cnt[0] + cnt[1] * cnt[1] + cnt[2] * cnt[2] >= lim) ||
               (n + 1 >= MaxRes);
      cells_due.push_back(c);
      n++;
    end
  endtask

  // Offers one ray and waits for its transfer. The valid may stay high for the next ray.
  task automatic send_ray(input ray_t r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
    do @(posedge clk_i); while (!s_axis_tready);
    walk_ray(r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Register writes happen only with the block idle. A ray with radius zero sends
  // nothing, so the bench also lets it run out before the write.
  task automatic write_reg(input logic idx, input logic [9:0] val);
    s_axis_tvalid <= 1'b0;
    wait (cells_due.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegRadius) radius_q = val[3:0];
    else eye_q = val;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 24'sh7F_FFFF : 24'sh80_0000;
      1, 2, 3: return 24'(int'($urandom_range(0, 4095)) - 2048);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic signed [15:0] rand_dir();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'($urandom());
      2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    r.ox = rand_coord();
    r.oy = rand_coord();
    r.oz = rand_coord();
    r.dx = rand_dir();
    r.dy = rand_dir();
    r.dz = rand_dir();
    return r;
  endfunction

  // True when two cells agree in every field.
  function automatic bit cell_same(input cell_t a, input cell_t b);
    return (a.cx === b.cx) && (a.cy === b.cy) && (a.cz === b.cz) &&
           (a.axis === b.axis) && (a.neg === b.neg) && (a.idx === b.idx) &&
           (a.last === b.last);
  endfunction

  // Receiver stalls come in bursts and stop in the quiet tail of the run.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compares every cell transfer, field by field, with the oldest predicted cell.
  always @(posedge clk_i) begin
    cell_t want, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.cx = m_axis_tdata[15:0];
      got.cy = m_axis_tdata[31:16];
      got.cz = m_axis_tdata[47:32];
      got.axis = axis_e'(m_axis_tdata[49:48]);
      got.neg = m_axis_tdata[50];
      got.idx = m_axis_tdata[54:51];
      got.last = m_axis_tlast;
      if (cells_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected cell %p", got);
      end else begin
        want = cells_due.pop_front();
        if (first_due) begin
          if (!cell_same(first_cell, got)) begin
            mismatches++;
            if (mismatches <= 10)
              $display("table cell mismatch: expected %p, actual %p", first_cell, got);
          end
          first_due = 1'b0;
        end
        if (!cell_same(want, got)) begin
          mismatches++;
          if (mismatches <= 10) $display("cell mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  // The watchdog ends a run in which no transfer of any kind happens for too long.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("voxel_ray_traversal verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic row_t mk_row(input int ox, oy, oz, dx, dy, dz);
    row_t w;
    w.ray.ox = 24'(ox);
    w.ray.oy = 24'(oy);
    w.ray.oz = 24'(oz);
    w.ray.dx = 16'(dx);
    w.ray.dy = 16'(dy);
    w.ray.dz = 16'(dz);
    w.has_first = 1'b0;
    return w;
  endfunction

  function automatic cell_t mk_cell(input int x, y, z, input axis_e ax, input bit neg);
    cell_t c;
    c.cx = 16'(x);
    c.cy = 16'(y);
    c.cz = 16'(z);
    c.axis = ax;
    c.neg = neg;
    c.idx = 0;
    c.last = 1'b0;
    return c;
  endfunction

  row_t rows[$];
  int radii[] = '{0, 1, 15, 8, 2, 5, 3, 7};
  int eyes[] = '{0, 1023, 384, 512, 77, 700, 256, 991};

  initial begin
    row_t w;
    // With the reset radius of four, the eye height of 1.5 puts a ray from the
    // origin into cell y = 1.
    w = mk_row(0, 0, 0, 0, 0, 0);  // no motion: every step falls to z in place
    w.has_first = 1'b1;
    w.first = mk_cell(0, 1, 0, AxisZ, 1'b0);
    rows.push_back(w);
    w = mk_row(0, 0, 0, 16384, 0, 0);
    w.has_first = 1'b1;
    w.first = mk_cell(1, 1, 0, AxisX, 1'b0);
    rows.push_back(w);
    w = mk_row(0, 0, 0, -16384, 0, 0);  // integer coordinate stepping down
    w.has_first = 1'b1;
    w.first = mk_cell(-1, 1, 0, AxisX, 1'b1);
    rows.push_back(w);
    rows.push_back(mk_row(0, 0, 0, 0, 16384, 0));
    rows.push_back(mk_row(0, 0, 0, 0, -16384, 0));
    rows.push_back(mk_row(0, 0, 0, 0, 0, 16384));
    rows.push_back(mk_row(0, 0, 0, 0, 0, -16384));
    rows.push_back(mk_row(8388607, 8388607, 8388607, 16384, 16384, 16384));
    rows.push_back(mk_row(-8388608, -8388608, -8388608, -16384, -16384, -16384));
    rows.push_back(mk_row(-256, -512, -768, -9000, -300, -12000));
    rows.push_back(mk_row(128, 64, 200, 32767, -32768, 1));
    rows.push_back(mk_row(5, 7, 9, 1, -1, 0));
    rows.push_back(mk_row(128, 128, 128, 11585, 11585, 0));  // equal x and y direction components
    rows.push_back(mk_row(8388607 - 300, 8388607, -8388608, -16384, 16384, 8000));
    rows.push_back(mk_row(65535 * 256, -32769 * 256, 32768 * 256, 700, -16384, -3));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      wait (!first_due);
      if (rows[i].has_first) begin
        // The first cell of this row is compared with the value typed in above.
        wait (cells_due.size() == 0);
        first_cell = rows[i].first;
        first_due = 1'b1;
      end
      send_ray(rows[i].ray);
    end

    for (int ph = 0; ph < radii.size(); ph++) begin
      write_reg(RegRadius, 10'(radii[ph]));
      write_reg(RegEye, 10'(eyes[ph]));
      if (ph == radii.size() - 1) quiet = 1'b1;
      repeat ((radii[ph] == 0) ? 8 : 34) send_ray(rand_ray());
    end
    s_axis_tvalid <= 1'b0;

    wait (cells_due.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("voxel_ray_traversal verification clean");
    end else begin
      $display("voxel_ray_traversal verification failed");
    end
    $finish;
  end
endmodule
